/* design/bpb_pkg.sv */
package bpb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int CNT_W     = 12;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_IDX_W = 8;
    localparam int RGB_W     = 24;
    localparam int COLOR_W   = 32;
    localparam int COORD_W   = 16;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // depth codes; code 3 is decoded as 32-bit
    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_24 = 2'd1;
    localparam logic [1:0] DEPTH_32 = 2'd2;

    typedef enum logic [2:0] {
        CFG_DEPTH_MODE       = 3'd0,
        CFG_IMAGE_WIDTH      = 3'd1,
        CFG_IMAGE_HEIGHT     = 3'd2,
        CFG_ORIGIN_X         = 3'd3,
        CFG_ORIGIN_Y         = 3'd4,
        CFG_BACKGROUND_COLOR = 3'd5,
        CFG_FOREGROUND_COLOR = 3'd6,
        CFG_USE_FOREGROUND   = 3'd7
    } cfg_reg_t;

    // pixel in flight between the assembly stage and the color stage
    typedef struct packed {
        logic                 mode8;
        logic [COLOR_W-1:0]   raw;
        logic [COORD_W-1:0]   sx;
        logic [COORD_W-1:0]   sy;
        logic                 done;
    } pix_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

/* design/bitmap_pixel_blitter.sv */
// Bitmap pixel blitter: turns a BMP pixel-array byte stream into one
// (screen x, screen y, color) request per pixel.
// Input stream s_*: s_tuser = 0 loads palette entry s_tdata[7:0] with the RGB
// value s_tdata[31:8]; s_tuser = 1 carries the next image byte in s_tdata[39:32].
// Output stream m_*: m_tdata = {color, y, x}, m_tlast marks the last pixel of the
// image. Rows are bottom-up: the first row lands at origin_y + height - 1.
// Config port: cfg_index selects the register, cfg_data is written; always ready.
// Write config only while the stream is idle.
// Throughput: one input request per cycle unless stalled, in every depth mode;
// a pixel is produced on the 1st, 3rd or 4th byte for 8, 24 and 32-bit modes.
// Path: the accepted byte that completes a pixel is held in stage 1 and the
// palette read register, then the color select goes into the output register.
// Stall: the assembly stage and the output register form a two-deep queue;
// s_tready drops only when both are full and m_tready is low.
// Reset: clears counters, byte assembly, queue and config registers
// (width = height = 1, all others 0). Palette contents are not cleared.
module bitmap_pixel_blitter
    import bpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // palette_index, palette_color, data_byte
    input  logic                  s_tuser,   // op

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // screen_x, screen_y, pixel_color
    output logic                  m_tlast,   // image_done

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    logic [1:0]         depth_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COORD_W-1:0] origin_x_reg;
    logic [COORD_W-1:0] origin_y_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic               use_fg_reg;

    logic [RGB_W-1:0]   acc_reg, acc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;

    logic [RGB_W-1:0]   pal_mem [PAL_DEPTH];
    logic [RGB_W-1:0]   pal_rdata_reg;

    logic               s1_valid_reg;
    pix_t               s1_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;
    logic               m_tlast_reg;

    logic [PAL_IDX_W-1:0] pal_idx;
    logic [RGB_W-1:0]     pal_color;
    logic [7:0]           data_byte;
    logic                 in_accept;
    logic                 pix_accept;
    logic                 pal_load;
    logic                 s1_advance;
    logic                 emit;
    logic [1:0]           need;
    logic [COLOR_W-1:0]   raw;
    logic                 col_last;
    logic                 row_last;
    pix_t                 pix;
    logic [COLOR_W-1:0]   val;
    logic [COLOR_W-1:0]   color;

    assign pal_idx   = s_tdata[7:0];
    assign pal_color = s_tdata[31:8];
    assign data_byte = s_tdata[39:32];

    assign cfg_ready  = 1'b1;
    assign s1_advance = !m_tvalid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_accept  = s_tvalid && s_tready;
    assign pix_accept = in_accept && (s_tuser == OP_PIXEL);
    assign pal_load   = in_accept && (s_tuser == OP_PALETTE);

    // config registers; width and height are clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= DEPTH_8;
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            bg_reg       <= '0;
            fg_reg       <= '0;
            use_fg_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEPTH_MODE:       depth_reg    <= cfg_data[1:0];
                CFG_IMAGE_WIDTH:      width_reg    <= clamp_dim(cfg_data[DIM_W-1:0]);
                CFG_IMAGE_HEIGHT:     height_reg   <= clamp_dim(cfg_data[DIM_W-1:0]);
                CFG_ORIGIN_X:         origin_x_reg <= cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:         origin_y_reg <= cfg_data[COORD_W-1:0];
                CFG_BACKGROUND_COLOR: bg_reg       <= cfg_data;
                CFG_FOREGROUND_COLOR: fg_reg       <= cfg_data;
                CFG_USE_FOREGROUND:   use_fg_reg   <= cfg_data[0];
                default:              use_fg_reg   <= use_fg_reg;
            endcase
        end
    end

    // byte assembly
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        emit     = 1'b0;
        raw      = '0;
        need     = (depth_reg == DEPTH_24) ? 2'd2 : 2'd3;
        if (depth_reg == DEPTH_8)
        begin
            acc_next = '0;
            cnt_next = '0;
            emit     = 1'b1;
        end
        else if (cnt_reg < need)
        begin
            case (cnt_reg)
                2'd0:    acc_next[7:0]   = acc_reg[7:0]   | data_byte;
                2'd1:    acc_next[15:8]  = acc_reg[15:8]  | data_byte;
                2'd2:    acc_next[23:16] = acc_reg[23:16] | data_byte;
                default: acc_next        = acc_reg;
            endcase
            cnt_next = cnt_reg + 2'd1;
        end
        else
        begin
            // enough bytes are in (also after a mode switch mid-pixel): this byte completes the pixel
            if (depth_reg == DEPTH_24)
            begin
                raw = {8'd0, data_byte, acc_reg[15:0]};
            end
            else
            begin
                raw = {data_byte, acc_reg};
            end
            acc_next = '0;
            cnt_next = '0;
            emit     = 1'b1;
        end
    end

    // position counters and screen coordinates
    always_comb
    begin
        col_last = (DIM_W'(col_reg) + DIM_W'(1)) >= width_reg;
        row_last = (DIM_W'(row_reg) + DIM_W'(1)) >= height_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
        end

        pix.mode8 = (depth_reg == DEPTH_8);
        pix.raw   = raw;
        pix.sx    = origin_x_reg + COORD_W'(col_reg);
        pix.sy    = origin_y_reg + COORD_W'(height_reg) - COORD_W'(1) - COORD_W'(row_reg);
        pix.done  = col_last && row_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_accept)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (emit)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // palette: written by load requests, read by image bytes
    always_ff @(posedge clk)
    begin
        if (pal_load)
        begin
            pal_mem[pal_idx] <= pal_color;
        end
        if (pix_accept)
        begin
            pal_rdata_reg <= pal_mem[data_byte];
        end
    end

    // stage 1 and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (pix_accept && emit)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                m_tvalid_reg <= s1_valid_reg;
            end
        end
    end

    always_comb
    begin
        val = s1_reg.mode8 ? {8'd0, pal_rdata_reg} : s1_reg.raw;
        if (val == '0)
        begin
            color = bg_reg;
        end
        else
        begin
            color = use_fg_reg ? fg_reg : val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept && emit)
        begin
            s1_reg <= pix;
        end
        if (s1_advance && s1_valid_reg)
        begin
            m_tdata_reg <= {color, s1_reg.sy, s1_reg.sx};
            m_tlast_reg <= s1_reg.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // accumulator holds gathered bytes only
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (acc_reg == '0))
        else $error("byte accumulator not clear at pixel start");

    // input backpressure only when both queue slots are full
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled with room in the queue");

    // every 8-bit image byte yields a palette pixel in stage 1
    a_mode8: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && depth_reg == DEPTH_8) |=> (s1_valid_reg && s1_reg.mode8))
        else $error("8-bit image byte lost");

    // a pixel in stage 1 stays while the output is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_tvalid_reg && !m_tready) |=> s1_valid_reg)
        else $error("stage 1 pixel dropped under stall");
`endif

endmodule

/* tb/tb_bitmap_pixel_blitter.sv */
module tb_bitmap_pixel_blitter;
    timeunit 1ns;
    timeprecision 1ps;

    import bpb_pkg::*;

    localparam logic [1:0] DEPTH_UNUSED = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SQUEEZE_AT    = 400;
    localparam int SQUEEZE_LEN   = 250;
    localparam int ITEM_TARGET   = 1550;
    localparam int CALM_FROM     = 1350;

    typedef struct packed {
        logic        op;
        logic [7:0]  pidx;
        logic [23:0] pcol;
        logic [7:0]  db;
    } blit_req_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] color;
        logic        done;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    bitmap_pixel_blitter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow of the block's registers and state
    logic [1:0]  sh_depth = DEPTH_8;
    logic [12:0] sh_width = 13'd1;
    logic [12:0] sh_height = 13'd1;
    logic [15:0] sh_org_x = '0;
    logic [15:0] sh_org_y = '0;
    logic [31:0] sh_bg = '0;
    logic [31:0] sh_fg = '0;
    logic        sh_use_fg = 1'b0;
    logic [23:0] sh_palette [PAL_DEPTH];
    logic [23:0] sh_acc = '0;
    int          sh_nbytes = 0;
    int          sh_col = 0;
    int          sh_row = 0;

    blit_req_t req_fifo [$];
    pixel_t    pixel_expect [$];
    bit        pal_loaded [PAL_DEPTH];
    bit        calm = 1'b0;
    int        items_made = 0;
    int        mismatches = 0;
    int        results_seen = 0;

    task automatic blit_step(input logic op, input logic [7:0] pidx,
                             input logic [23:0] pcol, input logic [7:0] b);
        logic [31:0] raw;
        int          w;
        int          h;
        int          need;
        pixel_t      px;
        if (op == OP_PALETTE)
        begin
            sh_palette[pidx] = pcol;
            return;
        end
        if (sh_depth == DEPTH_8)
        begin
            raw = {8'h00, sh_palette[b]};
        end
        else
        begin
            need = (sh_depth == DEPTH_24) ? 2 : 3;
            if (sh_nbytes < need)
            begin
                sh_acc = sh_acc | (24'(b) << (8 * sh_nbytes));
                sh_nbytes++;
                return;
            end
            if (need == 2)
                raw = {8'h00, b, sh_acc[15:0]};
            else
                raw = {b, sh_acc};
        end
        sh_acc = '0;
        sh_nbytes = 0;

        if (raw == '0)
            px.color = sh_bg;
        else
            px.color = sh_use_fg ? sh_fg : raw;

        w = (sh_width == 0) ? 1 : (sh_width > MAX_DIM) ? MAX_DIM : int'(sh_width);
        h = (sh_height == 0) ? 1 : (sh_height > MAX_DIM) ? MAX_DIM : int'(sh_height);
        px.x = 16'(int'(sh_org_x) + sh_col);
        px.y = 16'(int'(sh_org_y) + h - 1 - sh_row);
        px.done = 1'b0;
        // counters past a shrunken bound wrap on this pixel
        if (sh_col + 1 >= w)
        begin
            sh_col = 0;
            if (sh_row + 1 >= h)
            begin
                sh_row = 0;
                px.done = 1'b1;
            end
            else
            begin
                sh_row++;
            end
        end
        else
        begin
            sh_col++;
        end
        pixel_expect.push_back(px);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEPTH_MODE:       sh_depth = val[1:0];
            CFG_IMAGE_WIDTH:      sh_width = val[12:0];
            CFG_IMAGE_HEIGHT:     sh_height = val[12:0];
            CFG_ORIGIN_X:         sh_org_x = val[15:0];
            CFG_ORIGIN_Y:         sh_org_y = val[15:0];
            CFG_BACKGROUND_COLOR: sh_bg = val;
            CFG_FOREGROUND_COLOR: sh_fg = val;
            CFG_USE_FOREGROUND:   sh_use_fg = val[0];
            default: ;
        endcase
    endtask

    task automatic push_load(input logic [7:0] idx, input logic [23:0] col);
        blit_req_t r;
        r.op = OP_PALETTE;
        r.pidx = idx;
        r.pcol = col;
        r.db = 8'($urandom);
        req_fifo.push_back(r);
        pal_loaded[idx] = 1'b1;
        items_made++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        blit_req_t r;
        r.op = OP_PIXEL;
        r.pidx = 8'($urandom);
        r.pcol = 24'($urandom);
        r.db = b;
        req_fifo.push_back(r);
        items_made++;
    endtask

    // 8-bit pixels may only index entries that have been loaded
    function automatic logic [7:0] pick_loaded_index();
        logic [7:0] k;
        k = 8'($urandom_range(0, 255));
        while (!pal_loaded[k])
            k = k + 8'd1;
        return k;
    endfunction

    // wait for the stream to drain, then for the pipeline to settle
    task automatic wait_idle();
        while (req_fifo.size() != 0 || s_tvalid || pixel_expect.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [12:0] pick_dim();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'd8191;
            3: return 13'd4097;
            default: return 13'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_origin();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_color();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hffffffff;
        return $urandom;
    endfunction

    // request driver
    int drv_gap = 0;
    int drv_cycle = 0;
    bit drv_gappy = 1'b1;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                blit_step(s_tuser, s_tdata[7:0], s_tdata[31:8], s_tdata[39:32]);
                void'(req_fifo.pop_front());
            end
            drv_cycle++;
            if (drv_cycle % 97 == 0)
                drv_gappy = 1'($urandom_range(0, 1));
            if (s_tvalid && !s_tready)
            begin
                // hold the offered request
            end
            else if (drv_gap > 0)
            begin
                drv_gap--;
                s_tvalid <= 1'b0;
            end
            else if (req_fifo.size() != 0 && !calm && drv_gappy && $urandom_range(0, 4) == 0)
            begin
                drv_gap = $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end
            else if (req_fifo.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {req_fifo[0].db, req_fifo[0].pcol, req_fifo[0].pidx};
                s_tuser  <= req_fifo[0].op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    int     rx_hold = 0;
    int     mon_cycle = 0;
    bit     mon_gappy = 1'b1;
    bit     squeezed = 1'b0;
    pixel_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pixel_expect.size() == 0)
                begin
                    $error("unexpected pixel: x=%h y=%h color=%h done=%b",
                           m_tdata[15:0], m_tdata[31:16], m_tdata[63:32], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = pixel_expect.pop_front();
                    if (m_tdata[15:0] !== want.x)
                    begin
                        $error("screen_x: expected %h, got %h", want.x, m_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_tdata[31:16] !== want.y)
                    begin
                        $error("screen_y: expected %h, got %h", want.y, m_tdata[31:16]);
                        mismatches++;
                    end
                    if (m_tdata[63:32] !== want.color)
                    begin
                        $error("pixel_color: expected %h, got %h", want.color, m_tdata[63:32]);
                        mismatches++;
                    end
                    if (m_tlast !== want.done)
                    begin
                        $error("image_done: expected %b, got %b", want.done, m_tlast);
                        mismatches++;
                    end
                end
            end
            mon_cycle++;
            if (mon_cycle % 89 == 0)
                mon_gappy = 1'($urandom_range(0, 1));
            if (!squeezed && results_seen >= SQUEEZE_AT)
            begin
                // long back-pressure so the input side has to stall
                squeezed = 1'b1;
                rx_hold = SQUEEZE_LEN;
                m_tready <= 1'b0;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (!calm && mon_gappy && $urandom_range(0, 3) == 0)
            begin
                rx_hold = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    int quiet = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [1:0]  gen_depth;
        int          n;
        int          zero_run;
        int          r;
        logic [31:0] junk;

        zero_run = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // 8-bit: zero entry, full entry, x and y wrapping past 16 bits
        cfg_write(CFG_DEPTH_MODE, 32'(DEPTH_8));
        cfg_write(CFG_IMAGE_WIDTH, 32'd3);
        cfg_write(CFG_IMAGE_HEIGHT, 32'd2);
        cfg_write(CFG_ORIGIN_X, 32'hfffe);
        cfg_write(CFG_ORIGIN_Y, 32'hffff);
        cfg_write(CFG_BACKGROUND_COLOR, 32'hffffffff);
        cfg_write(CFG_FOREGROUND_COLOR, 32'h0);
        cfg_write(CFG_USE_FOREGROUND, 32'h0);
        @(negedge clk);
        push_load(8'd0, 24'h000000);
        push_load(8'd255, 24'hffffff);
        push_load(8'd1, 24'h123456);
        push_byte(8'd0);
        push_byte(8'd255);
        push_byte(8'd1);
        push_byte(8'd1);
        push_byte(8'd0);
        push_byte(8'd255);
        wait_idle();

        // 24-bit, zero and oversized geometry, foreground mode, load mid-pixel
        cfg_write(CFG_DEPTH_MODE, 32'(DEPTH_24));
        cfg_write(CFG_IMAGE_WIDTH, 32'd0);
        cfg_write(CFG_IMAGE_HEIGHT, 32'd8191);
        cfg_write(CFG_ORIGIN_X, 32'h0);
        cfg_write(CFG_ORIGIN_Y, 32'h0);
        cfg_write(CFG_BACKGROUND_COLOR, 32'h0);
        cfg_write(CFG_FOREGROUND_COLOR, 32'hffffffff);
        cfg_write(CFG_USE_FOREGROUND, 32'h1);
        @(negedge clk);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'hff);
        push_load(8'd2, 24'hffffff);
        push_byte(8'hff);
        wait_idle();

        // unused depth code behaves as 32-bit
        cfg_write(CFG_DEPTH_MODE, 32'(DEPTH_UNUSED));
        cfg_write(CFG_USE_FOREGROUND, 32'h0);
        @(negedge clk);
        repeat (4) push_byte(8'h00);
        repeat (4) push_byte(8'hff);
        wait_idle();

        while (items_made < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            gen_depth = (r < 3) ? DEPTH_8 : (r < 6) ? DEPTH_24 : (r < 9) ? DEPTH_32
                                                              : DEPTH_UNUSED;
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            cfg_write(CFG_DEPTH_MODE, {junk[31:2], gen_depth});
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            cfg_write(CFG_IMAGE_WIDTH, {junk[31:13], pick_dim()});
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            cfg_write(CFG_IMAGE_HEIGHT, {junk[31:13], pick_dim()});
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            cfg_write(CFG_ORIGIN_X, {junk[31:16], pick_origin()});
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            cfg_write(CFG_ORIGIN_Y, {junk[31:16], pick_origin()});
            cfg_write(CFG_BACKGROUND_COLOR, pick_color());
            cfg_write(CFG_FOREGROUND_COLOR, pick_color());
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            cfg_write(CFG_USE_FOREGROUND, {junk[31:1], 1'($urandom_range(0, 1))});

            @(negedge clk);
            if (items_made >= CALM_FROM)
                calm = 1'b1;
            n = $urandom_range(50, 110);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_load(8'($urandom), ($urandom_range(0, 7) == 0) ? 24'h0
                                                                       : 24'($urandom));
                end
                else if (gen_depth == DEPTH_8)
                begin
                    push_byte(pick_loaded_index());
                end
                else if (zero_run > 0)
                begin
                    zero_run--;
                    push_byte(8'h00);
                end
                else if ($urandom_range(0, 11) == 0)
                begin
                    // a run of zero bytes can yield background pixels
                    zero_run = 3;
                    push_byte(8'h00);
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    push_byte(8'hff);
                end
                else
                begin
                    push_byte(8'($urandom));
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (pixel_expect.size() != 0)
        begin
            $error("%0d pixels never arrived", pixel_expect.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
